// ----- rtl/iesm_pkg.sv -----
package iesm_pkg;

  // channels that keep statistics, and the number of store entries
  localparam int CHANNELS = 16;
  localparam int StoreDepth = 16;
  localparam int KeptChannels = (CHANNELS < StoreDepth) ? CHANNELS : StoreDepth;

  localparam int DataW = 32;
  localparam int MaskW = 16;
  localparam int ChanW = 4;
  localparam int OpW = 2;
  localparam int DivCntW = $clog2(DataW);

  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam logic [DataW-1:0] DataMax = '1;

  // opcodes of an input item
  localparam logic [OpW-1:0] OP_START = 2'd0;
  localparam logic [OpW-1:0] OP_STOP = 2'd1;
  localparam logic [OpW-1:0] OP_RECORD = 2'd2;
  localparam logic [OpW-1:0] OP_READ = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [MaskW-1:0] event_mask;
    logic [DataW-1:0] event_time;
    logic [ChanW-1:0] query_channel;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [DataW-1:0] event_count;
    logic [DataW-1:0] last_time;
    logic [DataW-1:0] mean_interval;
    logic [MaskW-1:0] last_event_mask;
    logic [MaskW-1:0] active_mask;
  } out_item_t;

  // what the back end has to do with an item
  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_ACK,
    CMD_REJECT,
    CMD_RECORD,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [MaskW-1:0] event_mask;
    logic [DataW-1:0] event_time;
    logic [ChanW-1:0] query_channel;
  } cmd_t;

endpackage

// ----- rtl/iesm_front.sv -----
module iesm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  iesm_pkg::in_item_t in_item_i,
  output logic               q_push_o,
  output iesm_pkg::cmd_t     q_cmd_o,
  input  logic               q_full_i
);
  import iesm_pkg::*;

  logic on_q, on_d;
  logic take;

  assign full_o = q_full_i;
  assign take = push_i && !q_full_i;
  assign q_push_o = take;

  // resolve every opcode against the on/off state here, so the back end sees only what takes effect
  always_comb begin
    on_d = on_q;
    q_cmd_o.event_mask = in_item_i.event_mask;
    q_cmd_o.event_time = in_item_i.event_time;
    q_cmd_o.query_channel = in_item_i.query_channel;
    q_cmd_o.kind = CMD_REJECT;
    case (in_item_i.opcode)
      OP_START: begin
        q_cmd_o.kind = CMD_CLEAR;
        on_d = 1'b1;
      end
      OP_STOP: begin
        if (on_q) begin
          q_cmd_o.kind = CMD_ACK;
        end
        on_d = 1'b0;
      end
      OP_RECORD: begin
        if (on_q) begin
          q_cmd_o.kind = CMD_RECORD;
        end
      end
      OP_READ: begin
        if (on_q) begin
          q_cmd_o.kind = CMD_READ;
        end
      end
      default: begin
        q_cmd_o.kind = CMD_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= 1'b0;
    end else if (take) begin
      on_q <= on_d;
    end
  end

endmodule

// ----- rtl/iesm_queue.sv -----
module iesm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  iesm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output iesm_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import iesm_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/iesm_div.sv -----
module iesm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [iesm_pkg::DataW-1:0] dividend_i,
  input  logic [iesm_pkg::DataW-1:0] divisor_i,
  output logic                       done_o,
  output logic [iesm_pkg::DataW-1:0] quotient_o
);
  import iesm_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   den_q;
  logic [DataW:0]     part, diff;
  logic               ge;

  always_comb begin
    part = {rem_q, quo_q[DataW-1]};
    diff = part - {1'b0, den_q};
    ge = (part >= {1'b0, den_q});
    rem_d = ge ? diff[DataW-1:0] : part[DataW-1:0];
    quo_d = {quo_q[DataW-2:0], ge};
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quotient_o = quo_d;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= DivCntW'(DataW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/iesm_back.sv -----
module iesm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iesm_pkg::cmd_t      q_cmd_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output iesm_pkg::out_item_t out_item_o
);
  import iesm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic             state_q, state_d;
  out_item_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic [MaskW-1:0] latest_q, latest_d;
  logic [MaskW-1:0] active_q, active_d;

  logic [DataW-1:0] count_q [StoreDepth];
  logic [DataW-1:0] last_q [StoreDepth];
  logic [DataW-1:0] sum_q [StoreDepth];

  logic             take, do_clear, do_record, div_start, div_done;
  logic [DataW-1:0] quotient;
  logic [DataW-1:0] rd_count, rd_sum;

  assign take = (state_q == ST_IDLE) && !q_empty_i && (!res_valid_q || pop_i);
  assign q_pop_o = take;
  assign do_clear = take && (q_cmd_i.kind == CMD_CLEAR);
  assign do_record = take && (q_cmd_i.kind == CMD_RECORD);
  assign rd_count = count_q[q_cmd_i.query_channel];
  assign rd_sum = sum_q[q_cmd_i.query_channel];
  assign div_start = take && (q_cmd_i.kind == CMD_READ) && (rd_count != '0);

  assign empty_o = !res_valid_q;
  assign out_item_o = res_q;

  // per-channel lanes: a clear clears all of them, and a record item updates those whose mask bit is set
  for (genvar i = 0; i < StoreDepth; i++) begin : g_lane
    if (i < KeptChannels) begin : g_kept
      logic [DataW-1:0] delta;
      logic [DataW:0]   acc;

      assign delta = q_cmd_i.event_time - last_q[i];
      assign acc = {1'b0, sum_q[i]} + {1'b0, delta};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          count_q[i] <= '0;
          last_q[i] <= '0;
          sum_q[i] <= '0;
        end else if (do_clear) begin
          count_q[i] <= '0;
          last_q[i] <= '0;
          sum_q[i] <= '0;
        end else if (do_record && q_cmd_i.event_mask[i]) begin
          if (count_q[i] != DataMax) begin
            count_q[i] <= count_q[i] + 1'b1;
          end
          sum_q[i] <= acc[DataW] ? DataMax : acc[DataW-1:0];
          last_q[i] <= q_cmd_i.event_time;
        end
      end
    end else begin : g_unkept
      assign count_q[i] = '0;
      assign last_q[i] = '0;
      assign sum_q[i] = '0;
    end
  end

  iesm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_sum),
    .divisor_i  (rd_count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    res_valid_d = res_valid_q;
    latest_d = latest_q;
    active_d = active_q;
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    if (take) begin
      res_d = '0;
      res_d.accepted = (q_cmd_i.kind != CMD_REJECT);
      res_valid_d = 1'b1;
      case (q_cmd_i.kind)
        CMD_CLEAR: begin
          latest_d = '0;
          active_d = '0;
        end
        CMD_RECORD: begin
          latest_d = q_cmd_i.event_mask;
          active_d = active_q | q_cmd_i.event_mask;
        end
        CMD_READ: begin
          res_d.event_count = rd_count;
          res_d.last_time = last_q[q_cmd_i.query_channel];
          res_d.last_event_mask = latest_q;
          res_d.active_mask = active_q;
          active_d = '0;
          if (rd_count != '0) begin
            res_valid_d = 1'b0;
            state_d = ST_DIV;
          end
        end
        default: begin
          res_d.accepted = (q_cmd_i.kind != CMD_REJECT);
        end
      endcase
    end
    if ((state_q == ST_DIV) && div_done) begin
      res_d.mean_interval = quotient;
      res_valid_d = 1'b1;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_valid_q <= 1'b0;
      latest_q <= '0;
      active_q <= '0;
    end else begin
      state_q <= state_d;
      res_valid_q <= res_valid_d;
      latest_q <= latest_d;
      active_q <= active_d;
    end
  end

endmodule

// ----- rtl/input_event_statistics_monitor_core.sv -----
// per-channel statistics of timestamped input events
// input side is a queue: an item goes in when push is high and full is low;
//   opcode start/clear, stop, record event or read channel
// result side is a queue too: the result item sits on out_item_o while empty
//   is low and leaves when pop is high
// every item gives exactly one result item, in order
// the front end decodes each item against the on/off state and writes it into
//   a two-entry command queue; the back end holds the channel stores
// start, stop and record finish in the back end without a divide, so they stream at
//   one item per cycle while results are taken
// a read with a nonzero count runs the 32-bit bit-serial divider for the mean
//   interval; the back end takes no new item until the divide is done
// if pop stays low the finished result waits in its register, the back end
//   stops, and the command queue fills up until full rises
// reset turns the monitor off and clears all stores and both masks at once
module input_event_statistics_monitor_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  iesm_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output iesm_pkg::out_item_t out_item_o
);
  import iesm_pkg::*;

  // command queue between front and back
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd_in, q_cmd_out;

  iesm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_item_i),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in),
    .q_full_i  (q_full)
  );

  iesm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out),
    .empty_o (q_empty)
  );

  // stores, divider and the result register
  iesm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_cmd_i    (q_cmd_out),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
